[rtl/core/epoch_seconds_to_calendar_top_defines.svh]
// assertion macros used by the checker file
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ESC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/esc_pkg.sv]
package esc_pkg;

    // field widths
    localparam int SECS_W   = 32;
    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // calendar constants
    localparam int EPOCH_YEAR         = 1970;
    localparam int SECONDS_PER_DAY    = 86400;
    localparam int SECONDS_PER_HOUR   = 3600;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int CENTURY            = 100;
    localparam int LEAP_FEB_DAYS      = 29;
    localparam int MONTHS             = 12;

    // subtract unit and working register widths
    localparam int OPND_W = 18;
    localparam int REM_W  = 17;
    localparam int LEN_W  = 9;
    localparam int DAYS_W = 16;

    // reciprocal multiplier widths
    localparam int DAY_PRE_SHIFT = 7;
    localparam int MUL_A_W       = SECS_W - DAY_PRE_SHIFT;
    localparam int MUL_B_W       = 26;
    localparam int MUL_P_W       = MUL_A_W + MUL_B_W;

    // days: (secs >> 7) * ceil(2^35 / 675) >> 35, as 86400 is 675 << 7
    localparam logic [MUL_B_W-1:0] DAY_RECIP = 26'd50903317;
    localparam int                 DAY_SHIFT = 35;

    // hour: (rem >> 4) * ceil(2^21 / 225) >> 21, as 3600 is 225 << 4
    localparam int                 HOUR_PRE_SHIFT = 4;
    localparam logic [MUL_B_W-1:0] HOUR_RECIP     = 26'd9321;
    localparam int                 HOUR_SHIFT     = 21;

    // minute: (rem >> 2) * ceil(2^14 / 15) >> 14, as 60 is 15 << 2
    localparam int                 MIN_PRE_SHIFT = 2;
    localparam logic [MUL_B_W-1:0] MIN_RECIP     = 26'd1093;
    localparam int                 MIN_SHIFT     = 14;

    // year of the epoch split into year in century and century modulo four
    localparam logic [YEAR_W-1:0] EPOCH_YIC  = YEAR_W'(EPOCH_YEAR % CENTURY);
    localparam logic [1:0]        EPOCH_CENT = 2'((EPOCH_YEAR / CENTURY) % 4);

    localparam logic [4:0] NORMAL_MONTH_LEN [MONTHS] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY,
        S_DAY_REM,
        S_HOUR,
        S_HOUR_REM,
        S_MIN,
        S_MIN_REM,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    // days in a month, month counted from one
    function automatic logic [LEN_W-1:0] esc_month_len(input logic [MONTH_W-1:0] month,
                                                       input logic leap);
        logic [MONTH_W-1:0] idx;
        idx = month - MONTH_W'(1);
        if (month == MONTH_W'(2) && leap) begin
            return LEN_W'(LEAP_FEB_DAYS);
        end
        return LEN_W'(NORMAL_MONTH_LEN[idx]);
    endfunction

endpackage

[rtl/core/epoch_seconds_to_calendar_top.sv]
// Converts a 32-bit count of seconds since midnight 1 January of the epoch year
// into year modulo 100, month, day, hour, minute and second (Gregorian leap rules).
// A request is taken when start is high and busy is low; busy then stays high until
// the result strobe o_valid, which lasts one cycle in the last busy cycle and cannot
// be stalled, so the receiver must capture the fields in that cycle. The day count,
// hour and minute are each found by a reciprocal multiplier step and then a
// remainder step in an 18-bit subtract-and-compare unit fed by that multiplier;
// the unit then takes one step per year and one per month plus one step to find
// the end of each loop, and a last state carries the strobe. The next request is
// taken in the cycle after the strobe.
module epoch_seconds_to_calendar_top
    import esc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SECS_W-1:0]   i_total_seconds,
    output logic                o_valid,
    output logic [YEAR_W-1:0]   o_year_in_century,
    output logic [MONTH_W-1:0]  o_month_number,
    output logic [DAY_W-1:0]    o_day_of_month,
    output logic [HOUR_W-1:0]   o_hour_of_day,
    output logic [MINUTE_W-1:0] o_minute_of_hour,
    output logic [SECOND_W-1:0] o_second_of_minute
);

    t_state               r_state, n_state;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [SECS_W-1:0]    r_quo, n_quo;
    logic [HOUR_W-1:0]    r_hour, n_hour;
    logic [MINUTE_W-1:0]  r_min, n_min;
    logic [YEAR_W-1:0]    r_yic, n_yic;
    logic [1:0]           r_cent, n_cent;
    logic [MONTH_W-1:0]   r_month, n_month;

    logic [MUL_A_W-1:0]   w_mul_a;
    logic [MUL_B_W-1:0]   w_mul_b;
    logic [MUL_P_W-1:0]   w_prod;
    logic [OPND_W-1:0]    w_op_a, w_op_b;
    logic [OPND_W:0]      w_diff;
    logic                 w_ge;
    logic                 w_leap;

    // leap year from year in century and century modulo four
    assign w_leap = (r_yic[1:0] == 2'b00) && ((r_yic != '0) || (r_cent == 2'b00));

    // reciprocal multiplier, operands picked by the sequencer
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_DAY: begin
                w_mul_a = MUL_A_W'(r_quo >> DAY_PRE_SHIFT);
                w_mul_b = DAY_RECIP;
            end
            S_DAY_REM: begin
                w_mul_a = MUL_A_W'(r_quo[DAYS_W-1:0]);
                w_mul_b = MUL_B_W'(SECONDS_PER_DAY);
            end
            S_HOUR: begin
                w_mul_a = MUL_A_W'(r_rem >> HOUR_PRE_SHIFT);
                w_mul_b = HOUR_RECIP;
            end
            S_HOUR_REM: begin
                w_mul_a = MUL_A_W'(r_hour);
                w_mul_b = MUL_B_W'(SECONDS_PER_HOUR);
            end
            S_MIN: begin
                w_mul_a = MUL_A_W'(r_rem >> MIN_PRE_SHIFT);
                w_mul_b = MIN_RECIP;
            end
            S_MIN_REM: begin
                w_mul_a = MUL_A_W'(r_min);
                w_mul_b = MUL_B_W'(SECONDS_PER_MINUTE);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = {{(MUL_P_W-MUL_A_W){1'b0}}, w_mul_a} *
                    {{(MUL_P_W-MUL_B_W){1'b0}}, w_mul_b};

    // shared subtract and compare unit, operands picked by the sequencer
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            S_DAY_REM, S_HOUR_REM, S_MIN_REM: begin
                w_op_a = {1'b0, r_rem};
                w_op_b = w_prod[OPND_W-1:0];
            end
            S_YEAR: begin
                w_op_a = r_quo[OPND_W-1:0];
                w_op_b = w_leap ? OPND_W'(366) : OPND_W'(365);
            end
            S_MONTH: begin
                w_op_a = r_quo[OPND_W-1:0];
                w_op_b = OPND_W'(esc_month_len(r_month, w_leap));
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_diff = {1'b0, w_op_a} - {1'b0, w_op_b};
    assign w_ge   = !w_diff[OPND_W];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                n_state = S_DAY_REM;
            end
            S_DAY_REM: begin
                n_state = S_HOUR;
            end
            S_HOUR: begin
                n_state = S_HOUR_REM;
            end
            S_HOUR_REM: begin
                n_state = S_MIN;
            end
            S_MIN: begin
                n_state = S_MIN_REM;
            end
            S_MIN_REM: begin
                n_state = S_YEAR;
            end
            S_YEAR: begin
                if (!w_ge) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (r_month == MONTH_W'(MONTHS) || !w_ge) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath updates per step
    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_hour  = r_hour;
        n_min   = r_min;
        n_yic   = r_yic;
        n_cent  = r_cent;
        n_month = r_month;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_quo   = i_total_seconds;
                    n_month = MONTH_W'(1);
                    n_yic   = EPOCH_YIC;
                    n_cent  = EPOCH_CENT;
                end
            end
            S_DAY: begin
                // low bits of the seconds suffice, the remainder is below 2^17
                n_rem = r_quo[REM_W-1:0];
                n_quo = SECS_W'(w_prod[DAY_SHIFT +: DAYS_W]);
            end
            S_DAY_REM, S_HOUR_REM, S_MIN_REM: begin
                n_rem = w_diff[REM_W-1:0];
            end
            S_HOUR: begin
                n_hour = w_prod[HOUR_SHIFT +: HOUR_W];
            end
            S_MIN: begin
                n_min = w_prod[MIN_SHIFT +: MINUTE_W];
            end
            S_YEAR: begin
                if (w_ge) begin
                    n_quo = SECS_W'(w_diff[OPND_W-1:0]);
                    if (r_yic == YEAR_W'(CENTURY - 1)) begin
                        n_yic  = '0;
                        n_cent = r_cent + 2'd1;
                    end else begin
                        n_yic = r_yic + YEAR_W'(1);
                    end
                end
            end
            S_MONTH: begin
                if (r_month != MONTH_W'(MONTHS) && w_ge) begin
                    n_quo   = SECS_W'(w_diff[OPND_W-1:0]);
                    n_month = r_month + MONTH_W'(1);
                end
            end
            default: begin
                n_rem = r_rem;
            end
        endcase
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_hour  <= n_hour;
        r_min   <= n_min;
        r_yic   <= n_yic;
        r_cent  <= n_cent;
        r_month <= n_month;
    end

    // handshake and result ports
    assign busy               = (r_state != S_IDLE);
    assign o_valid            = (r_state == S_DONE);
    assign o_year_in_century  = r_yic;
    assign o_month_number     = r_month;
    assign o_day_of_month     = r_quo[DAY_W-1:0] + DAY_W'(1);
    assign o_hour_of_day      = r_hour;
    assign o_minute_of_hour   = r_min;
    assign o_second_of_minute = r_rem[SECOND_W-1:0];

endmodule

[rtl/core/esc_checker.sv]
`include "epoch_seconds_to_calendar_top_defines.svh"

module esc_checker
    import esc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [SECS_W-1:0]   i_total_seconds,
    input logic                o_valid,
    input logic [YEAR_W-1:0]   o_year_in_century,
    input logic [MONTH_W-1:0]  o_month_number,
    input logic [DAY_W-1:0]    o_day_of_month,
    input logic [HOUR_W-1:0]   o_hour_of_day,
    input logic [MINUTE_W-1:0] o_minute_of_hour,
    input logic [SECOND_W-1:0] o_second_of_minute
);

    // a taken request keeps the block busy
    `ESC_ASSERT_NEXT(a_req_busy, start && !busy, busy, "request taken but busy not raised")

    // result strobe only ends a busy period
    `ESC_ASSERT_SAME(a_valid_busy, o_valid, busy, "result strobe outside busy period")

    // strobe is one cycle wide and frees the block
    `ESC_ASSERT_NEXT(a_valid_pulse, o_valid, !o_valid && !busy, "result strobe not a single pulse")

    // busy drops only after a result
    `ESC_ASSERT_SAME(a_fall_after_valid, $fell(busy) && $past(i_rst_n), $past(o_valid), "busy fell without a result")

    // result fields lie in calendar range
    `ESC_ASSERT_SAME(a_fields_range, o_valid, (o_year_in_century <= YEAR_W'(99)) && (o_month_number >= MONTH_W'(1)) && (o_month_number <= MONTH_W'(12)) && (o_day_of_month >= DAY_W'(1)) && (o_hour_of_day <= HOUR_W'(23)) && (o_minute_of_hour <= MINUTE_W'(59)) && (o_second_of_minute <= SECOND_W'(59)), "result field out of range")

endmodule

bind epoch_seconds_to_calendar_top esc_checker u_esc_checker (.*);

[test/epoch_seconds_to_calendar_top_tb.sv]
module epoch_seconds_to_calendar_top_tb;
    import esc_pkg::*;

    localparam int unsigned DAY_SECS    = 86400;
    localparam int unsigned HOUR_SECS   = 3600;
    localparam int unsigned MINUTE_SECS = 60;
    localparam int          RANDOM_REQS = 1330;
    localparam int          SETTLE_CYCLES = 250;
    localparam longint      CYCLE_LIMIT = 3_000_000;
    localparam int          MAX_PRINTED = 30;

    // calendar fields at the widths of the result ports
    typedef struct {
        logic [YEAR_W-1:0]   yic;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_cal;

    // one conversion waiting for its result
    typedef struct {
        logic [SECS_W-1:0] secs;
        t_cal              cal;
    } t_date_due;

    // one request still to be sent
    typedef struct {
        logic [SECS_W-1:0] secs;
        int unsigned       gap;
        bit                drain;
    } t_request;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic [SECS_W-1:0]   i_total_seconds = '0;
    logic                busy;
    logic                o_valid;
    logic [YEAR_W-1:0]   o_year_in_century;
    logic [MONTH_W-1:0]  o_month_number;
    logic [DAY_W-1:0]    o_day_of_month;
    logic [HOUR_W-1:0]   o_hour_of_day;
    logic [MINUTE_W-1:0] o_minute_of_hour;
    logic [SECOND_W-1:0] o_second_of_minute;

    t_request  request_q [$];
    t_date_due dates_due [$];

    int     driven_cnt = 0;
    int     accepted_cnt = 0;
    int     checked_cnt = 0;
    int     idle_cnt = 0;
    int     error_cnt = 0;
    int     feb29_cnt = 0;
    int     modern_cnt = 0;
    longint cycle_cnt = 0;

    epoch_seconds_to_calendar_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_total_seconds    (i_total_seconds),
        .o_valid            (o_valid),
        .o_year_in_century  (o_year_in_century),
        .o_month_number     (o_month_number),
        .o_day_of_month     (o_day_of_month),
        .o_hour_of_day      (o_hour_of_day),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_second_of_minute (o_second_of_minute)
    );

    always #5 i_clk = ~i_clk;

    // gregorian rule on the full year
    function automatic bit is_leap(input int unsigned year);
        if (year % 400 == 0) return 1'b1;
        if (year % 100 == 0) return 1'b0;
        return year % 4 == 0;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned month, input bit leap);
        case (month)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // expected calendar time for a second count
    function automatic t_cal calendar_of(input logic [SECS_W-1:0] secs);
        t_cal        c;
        int unsigned s;
        int unsigned days;
        int unsigned rem;
        int unsigned year;
        int unsigned month;
        bit          leap;
        s     = secs;
        days  = s / DAY_SECS;
        rem   = s % DAY_SECS;
        year  = EPOCH_YEAR;
        month = 1;
        while (days >= (is_leap(year) ? 366 : 365)) begin
            days -= is_leap(year) ? 366 : 365;
            year++;
        end
        leap = is_leap(year);
        while (month < 12 && days >= days_in_month(month, leap)) begin
            days -= days_in_month(month, leap);
            month++;
        end
        c.yic    = YEAR_W'(year % 100);
        c.month  = MONTH_W'(month);
        c.day    = DAY_W'(days + 1);
        c.hour   = HOUR_W'(rem / HOUR_SECS);
        c.minute = MINUTE_W'((rem % HOUR_SECS) / MINUTE_SECS);
        c.second = SECOND_W'(rem % MINUTE_SECS);
        return c;
    endfunction

    // second count of a calendar time, may exceed 32 bits
    function automatic longint unsigned secs_at(input int unsigned y, input int unsigned m,
                                                input int unsigned d, input int unsigned hh,
                                                input int unsigned mm, input int unsigned ss);
        longint unsigned days;
        days = 0;
        for (int unsigned yy = EPOCH_YEAR; yy < y; yy++) days += is_leap(yy) ? 366 : 365;
        for (int unsigned mo = 1; mo < m; mo++) days += days_in_month(mo, is_leap(y));
        days += d - 1;
        return days * DAY_SECS + hh * HOUR_SECS + mm * MINUTE_SECS + ss;
    endfunction

    // idle cycles before a request: mostly short, a few long
    function automatic int unsigned pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return 0;
        if (sel < 85) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // random second count, biased toward month and year edges, 29 February and both ends of the range
    function automatic logic [SECS_W-1:0] pick_secs();
        int unsigned     sel;
        int unsigned     y;
        int unsigned     m;
        int unsigned     d;
        int unsigned     len;
        longint unsigned v;
        sel = $urandom_range(0, 99);
        if (sel < 45) return $urandom;
        if (sel < 80) begin
            y   = $urandom_range(EPOCH_YEAR, EPOCH_YEAR + 136);
            m   = $urandom_range(1, 12);
            len = days_in_month(m, is_leap(y));
            case ($urandom_range(0, 3))
                0:       d = 1;
                1:       d = 2;
                2:       d = len - 1;
                default: d = len;
            endcase
            if (is_leap(y) && $urandom_range(0, 3) == 0) begin
                m = 2;
                d = 29;
            end
            case ($urandom_range(0, 2))
                0:       v = secs_at(y, m, d, 0, 0, 0);
                1:       v = secs_at(y, m, d, 23, 59, 59);
                default: v = secs_at(y, m, d, $urandom_range(0, 23), $urandom_range(0, 59),
                                     $urandom_range(0, 59));
            endcase
            if (v > 64'hFFFF_FFFF) return $urandom;
            return SECS_W'(v);
        end
        if (sel < 90) return $urandom_range(0, 3 * DAY_SECS);
        return 32'hFFFF_FFFF - $urandom_range(0, 40 * DAY_SECS);
    endfunction

    task automatic queue_request(input longint unsigned secs, input int unsigned gap,
                                 input bit drain);
        t_request r;
        r.secs  = SECS_W'(secs);
        r.gap   = gap;
        r.drain = drain;
        request_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        error_cnt++;
        if (error_cnt <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want, input logic [SECS_W-1:0] secs);
        if (got != want)
            report_mismatch($sformatf("%s for %0d seconds: got %0d, want %0d",
                                      name, secs, got, want));
    endtask

    // sender: drops start once a request is taken, then waits its gap
    always @(negedge i_clk) begin : drive_proc
        t_request nxt;
        logic     go;
        go = start;
        if (i_rst_n) begin
            if (start && accepted_cnt == driven_cnt) go = 1'b0;
            if (!go) begin
                if (request_q.size() > 0 && idle_cnt >= request_q[0].gap &&
                    (!request_q[0].drain || dates_due.size() == 0)) begin
                    nxt = request_q.pop_front();
                    i_total_seconds <= nxt.secs;
                    driven_cnt++;
                    idle_cnt = 0;
                    go = 1'b1;
                end else begin
                    idle_cnt++;
                end
            end
        end
        start <= go;
    end

    // result check first, then record a newly taken request
    always @(posedge i_clk) begin : monitor_proc
        t_date_due due;
        if (i_rst_n) begin
            if (o_valid) begin
                if (dates_due.size() == 0) begin
                    report_mismatch("result strobe with no request outstanding");
                end else begin
                    due = dates_due.pop_front();
                    checked_cnt++;
                    check_field("year", o_year_in_century, due.cal.yic, due.secs);
                    check_field("month", o_month_number, due.cal.month, due.secs);
                    check_field("day", o_day_of_month, due.cal.day, due.secs);
                    check_field("hour", o_hour_of_day, due.cal.hour, due.secs);
                    check_field("minute", o_minute_of_hour, due.cal.minute, due.secs);
                    check_field("second", o_second_of_minute, due.cal.second, due.secs);
                    if (due.cal.month == 2 && due.cal.day == 29) feb29_cnt++;
                    if (due.cal.yic < 70) modern_cnt++;
                end
            end
            if (start && !busy) begin
                due.secs = i_total_seconds;
                due.cal  = calendar_of(i_total_seconds);
                dates_due.push_back(due);
                accepted_cnt++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, dates_due.size());
            $display("epoch_seconds_to_calendar_top verification failed");
            $finish;
        end
    end

    initial begin
        // directed: field extremes, leap days, century years, 2038 and the top of the range
        queue_request(0, pick_gap(), 1'b0);
        queue_request(32'hFFFF_FFFF, pick_gap(), 1'b0);
        queue_request(32'hFFFF_FFFE, pick_gap(), 1'b0);
        queue_request(DAY_SECS - 1, pick_gap(), 1'b0);
        queue_request(DAY_SECS, pick_gap(), 1'b0);
        queue_request(secs_at(1970, 1, 31, 23, 59, 59), pick_gap(), 1'b0);
        queue_request(secs_at(1970, 12, 31, 23, 59, 59), pick_gap(), 1'b0);
        queue_request(secs_at(1972, 2, 29, 12, 30, 30), pick_gap(), 1'b0);
        queue_request(secs_at(1972, 12, 31, 0, 0, 0), pick_gap(), 1'b0);
        queue_request(secs_at(1999, 12, 31, 23, 59, 59), pick_gap(), 1'b0);
        queue_request(secs_at(2000, 2, 29, 1, 2, 3), pick_gap(), 1'b0);
        queue_request(secs_at(2000, 12, 31, 23, 0, 0), pick_gap(), 1'b0);
        queue_request(secs_at(2001, 2, 28, 23, 59, 59), pick_gap(), 1'b0);
        queue_request(secs_at(2001, 3, 1, 0, 0, 0), pick_gap(), 1'b0);
        queue_request(32'h7FFF_FFFF, pick_gap(), 1'b0);
        queue_request(32'h8000_0000, pick_gap(), 1'b0);
        queue_request(32'hAAAA_AAAA, pick_gap(), 1'b0);
        queue_request(32'h5555_5555, pick_gap(), 1'b0);
        queue_request(secs_at(2099, 12, 31, 23, 59, 59), pick_gap(), 1'b0);
        queue_request(secs_at(2100, 1, 1, 0, 0, 0), pick_gap(), 1'b0);
        queue_request(secs_at(2100, 2, 28, 23, 59, 59), pick_gap(), 1'b0);
        queue_request(secs_at(2100, 3, 1, 0, 0, 0), pick_gap(), 1'b0);
        queue_request(secs_at(2104, 2, 29, 0, 0, 0), pick_gap(), 1'b0);
        queue_request(secs_at(2105, 12, 31, 23, 59, 59), pick_gap(), 1'b0);

        // random: some windows without idling, a full drain now and then
        for (int i = 0; i < RANDOM_REQS; i++) begin
            queue_request(pick_secs(), ((i / 100) % 4 == 1) ? 0 : pick_gap(), i % 300 == 0);
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() > 0 || driven_cnt != accepted_cnt || dates_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked in %0d cycles", accepted_cnt,
                 checked_cnt, cycle_cnt);
        $display("%0d results on 29 February, %0d with a two-digit year below 70", feb29_cnt,
                 modern_cnt);
        if (error_cnt == 0) begin
            $display("epoch_seconds_to_calendar_top verification clean");
        end else begin
            $display("%0d mismatches", error_cnt);
            $display("epoch_seconds_to_calendar_top verification failed");
        end
        $finish;
    end

endmodule

[epoch_seconds_to_calendar_top.f]
+incdir+rtl/core
rtl/core/esc_pkg.sv
rtl/core/epoch_seconds_to_calendar_top.sv
rtl/core/esc_checker.sv
test/epoch_seconds_to_calendar_top_tb.sv
